// ===== hw/rtl/phf_pkg.sv =====
// Shared types and constants of the packet header filter.
package phf_pkg;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 7;
  localparam int LEN_W  = 8;
  localparam int DATA_W = 32;

  localparam logic [15:0] ETH_KIND_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_KIND_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [15:0] PORT_DNS      = 16'd53;

  localparam logic [OFF_W-1:0] OFF_KIND_HI  = 7'd12;
  localparam logic [OFF_W-1:0] OFF_KIND_LO  = 7'd13;
  localparam logic [OFF_W-1:0] OFF_IP_START = 7'd14;
  localparam logic [OFF_W-1:0] OFF_PROTO    = 7'd23;
  localparam logic [OFF_W-1:0] OFF_SRC_LO   = 7'd26;
  localparam logic [OFF_W-1:0] OFF_SRC_HI   = 7'd29;
  localparam logic [OFF_W-1:0] OFF_DST_LO   = 7'd30;
  localparam logic [OFF_W-1:0] OFF_DST_HI   = 7'd33;
  localparam logic [OFF_W-1:0] OFF_MAX      = 7'd127;

  localparam logic [LEN_W-1:0] LEN_ETH_MIN  = 8'd14;
  localparam logic [LEN_W-1:0] LEN_IPV4_MIN = 8'd34;
  localparam logic [LEN_W-1:0] PORT_SPAN    = 8'd4;

  typedef enum logic [2:0] {
    MODE_ALL   = 3'd0,
    MODE_ARP   = 3'd1,
    MODE_HTTP  = 3'd2,
    MODE_HTTPS = 3'd3,
    MODE_DNS   = 3'd4,
    MODE_TCP   = 3'd5,
    MODE_UDP   = 3'd6
  } filter_mode_t;

  typedef enum logic [2:0] {
    REG_FILTER_MODE     = 3'd0,
    REG_MATCH_PROTOCOL  = 3'd1,
    REG_MATCH_SRC_ADDR  = 3'd2,
    REG_SRC_ADDR_ENABLE = 3'd3,
    REG_MATCH_DST_ADDR  = 3'd4,
    REG_DST_ADDR_ENABLE = 3'd5,
    REG_MATCH_SRC_PORT  = 3'd6,
    REG_MATCH_DST_PORT  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0]      ether_kind;
    logic [7:0]       ip_protocol;
    logic [31:0]      source_addr;
    logic [31:0]      dest_addr;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [LEN_W-1:0] frame_len;
    logic [OFF_W-1:0] port_pos;
  } frame_sum_t;

  typedef struct packed {
    logic       valid;
    frame_sum_t sum;
  } q_beat_t;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic [7:0]  match_protocol;
    logic [31:0] match_src_addr;
    logic        src_addr_enable;
    logic [31:0] match_dst_addr;
    logic        dst_addr_enable;
    logic [15:0] match_src_port;
    logic [15:0] match_dst_port;
  } cfg_t;

endpackage

// ===== hw/rtl/phf_in_if.sv =====
// Frame byte channel: one frame byte per beat.
interface phf_in_if;
  logic                       valid;
  logic                       ready;
  logic [phf_pkg::BYTE_W-1:0] frame_byte;
  logic                       frame_end;

  modport source(output valid, frame_byte, frame_end, input ready);
  modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

// ===== hw/rtl/phf_out_if.sv =====
// Verdict channel: one verdict per frame.
interface phf_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic too_short;

  modport source(output valid, accepted, too_short, input ready);
  modport sink(input valid, accepted, too_short, output ready);
endinterface

// ===== hw/rtl/packet_header_filter.sv =====
// Top level of the Ethernet/IPv4/TCP/UDP packet header filter.
// Use: frames enter on in_ch one byte per beat in wire order, frame_end set
// on the last byte. Each frame yields exactly one beat on out_ch with
// accepted and too_short; no other byte produces an output beat.
// Setup goes through cfg_we/cfg_index/cfg_data (indexes per reg_index_t),
// written while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full, sustained
// across frame boundaries. The front end captures header fields as bytes
// pass; on the last byte it pushes a frame summary into a QUEUE_DEPTH
// entry queue. The verdict is registered: the summary is written into the
// queue, then judged into the output register when the queue pops it.
// Stall: while out_ch.ready is low the verdict holds; later summaries
// collect in the queue, and in_ch.ready drops only once the queue is full.
// Reset: setup registers return to zero (mode all, no address or port
// matching), the queue empties and the byte count starts at zero.
module packet_header_filter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  phf_in_if.sink                     in_ch,
  phf_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [phf_pkg::DATA_W-1:0] cfg_data
);
  import phf_pkg::*;

  q_beat_t q_wr;
  q_beat_t q_rd;
  logic    q_full;
  logic    q_pop;

  phf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  phf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  phf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/phf_front.sv =====
// Front end: walks frame bytes and captures the header fields.
module phf_front (
  input  logic             clk,
  input  logic             rst_n,
  phf_in_if.sink           in_ch,
  input  logic             q_full,
  output phf_pkg::q_beat_t q_wr
);
  import phf_pkg::*;

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [15:0]      kind_r, kind_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [3:0]       words_r, words_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [OFF_W-1:0] pp;
  logic [7:0]       b;
  logic             live;
  logic             beat;

  assign in_ch.ready = !q_full;
  assign beat        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.frame_byte;
  assign live        = (off_r != OFF_MAX);

  always_comb begin
    words_nxt = words_r;
    if (live && off_r == OFF_IP_START) begin
      words_nxt = b[3:0];
    end
    pp = OFF_IP_START + {1'b0, words_nxt, 2'b00};

    kind_nxt  = kind_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    off_nxt   = off_r;
    if (live) begin
      if (off_r == OFF_KIND_HI || off_r == OFF_KIND_LO) begin
        kind_nxt = {kind_r[7:0], b};
      end
      if (off_r == OFF_PROTO) begin
        proto_nxt = b;
      end
      if (off_r >= OFF_SRC_LO && off_r <= OFF_SRC_HI) begin
        src_nxt = {src_r[23:0], b};
      end
      if (off_r >= OFF_DST_LO && off_r <= OFF_DST_HI) begin
        dst_nxt = {dst_r[23:0], b};
      end
      if (off_r == pp || off_r == pp + 7'd1) begin
        sport_nxt = {sport_r[7:0], b};
      end
      if (off_r == pp + 7'd2 || off_r == pp + 7'd3) begin
        dport_nxt = {dport_r[7:0], b};
      end
      off_nxt = off_r + 7'd1;
    end

    q_wr.valid           = beat && in_ch.frame_end;
    q_wr.sum.ether_kind  = kind_nxt;
    q_wr.sum.ip_protocol = proto_nxt;
    q_wr.sum.source_addr = src_nxt;
    q_wr.sum.dest_addr   = dst_nxt;
    q_wr.sum.source_port = sport_nxt;
    q_wr.sum.dest_port   = dport_nxt;
    q_wr.sum.frame_len   = {1'b0, off_r} + 8'd1;
    q_wr.sum.port_pos    = pp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && in_ch.frame_end)) begin
      off_r   <= '0;
      kind_r  <= '0;
      proto_r <= '0;
      words_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (beat) begin
      off_r   <= off_nxt;
      kind_r  <= kind_nxt;
      proto_r <= proto_nxt;
      words_r <= words_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("frame summary pushed into a full queue");

endmodule

// ===== hw/rtl/phf_queue.sv =====
// Short queue of frame summaries between front and back end.
module phf_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  phf_pkg::q_beat_t wr,
  output logic             full,
  input  logic             pop,
  output phf_pkg::q_beat_t rd
);
  import phf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  frame_sum_t          mem_r [DEPTH];
  logic [PtrW-1:0]     wp_r, rp_r;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                push;

  assign push   = wr.valid && !full;
  assign full   = (cnt_r == FullCnt);
  assign rd.valid = (cnt_r != '0);
  assign rd.sum   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && rd.valid)) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (!push && pop && rd.valid) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == LastPtr) ? '0 : wp_r + PtrW'(1);
      end
      if (pop && rd.valid) begin
        rp_r <= (rp_r == LastPtr) ? '0 : rp_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr.sum;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd.valid)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FullCnt)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + CntW'(1))
    else $error("queue count missed a push");

endmodule

// ===== hw/rtl/phf_back.sv =====
// Back end: holds the filter setup, judges each frame, drives the verdict.
module phf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [phf_pkg::DATA_W-1:0] cfg_data,
  input  phf_pkg::q_beat_t          q_rd,
  output logic                      q_pop,
  phf_out_if.source                 out_ch
);
  import phf_pkg::*;

  cfg_t       cfg_r;
  frame_sum_t s;
  logic       acc, shortf;
  logic       tcp, udp, ports_ok;
  logic       out_valid_r, accepted_r, too_short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FILTER_MODE:     cfg_r.filter_mode     <= cfg_data[2:0];
        REG_MATCH_PROTOCOL:  cfg_r.match_protocol  <= cfg_data[7:0];
        REG_MATCH_SRC_ADDR:  cfg_r.match_src_addr  <= cfg_data[31:0];
        REG_SRC_ADDR_ENABLE: cfg_r.src_addr_enable <= cfg_data[0];
        REG_MATCH_DST_ADDR:  cfg_r.match_dst_addr  <= cfg_data[31:0];
        REG_DST_ADDR_ENABLE: cfg_r.dst_addr_enable <= cfg_data[0];
        REG_MATCH_SRC_PORT:  cfg_r.match_src_port  <= cfg_data[15:0];
        REG_MATCH_DST_PORT:  cfg_r.match_dst_port  <= cfg_data[15:0];
      endcase
    end
  end

  assign s   = q_rd.sum;
  assign tcp = (s.ip_protocol == PROTO_TCP);
  assign udp = (s.ip_protocol == PROTO_UDP);
  assign ports_ok =
    (cfg_r.match_src_port == '0 || s.source_port == cfg_r.match_src_port) &&
    (cfg_r.match_dst_port == '0 || s.dest_port == cfg_r.match_dst_port);

  always_comb begin
    acc    = 1'b0;
    shortf = 1'b0;
    priority if (s.frame_len < LEN_ETH_MIN) begin
      shortf = 1'b1;
    end else if (cfg_r.filter_mode == MODE_ARP) begin
      acc = (s.ether_kind == ETH_KIND_ARP);
    end else if (s.ether_kind != ETH_KIND_IPV4) begin
      acc = 1'b0;
    end else if (s.frame_len < LEN_IPV4_MIN) begin
      shortf = 1'b1;
    end else if ((tcp || udp) && s.frame_len < ({1'b0, s.port_pos} + PORT_SPAN)) begin
      shortf = 1'b1;
    end else if (cfg_r.match_protocol != '0 && s.ip_protocol != cfg_r.match_protocol) begin
      acc = 1'b0;
    end else if (cfg_r.src_addr_enable && s.source_addr != cfg_r.match_src_addr) begin
      acc = 1'b0;
    end else if (cfg_r.dst_addr_enable && s.dest_addr != cfg_r.match_dst_addr) begin
      acc = 1'b0;
    end else if (tcp && cfg_r.filter_mode == MODE_HTTP) begin
      acc = (s.source_port == PORT_HTTP) || (s.dest_port == PORT_HTTP);
    end else if (tcp && cfg_r.filter_mode == MODE_HTTPS) begin
      acc = (s.source_port == PORT_HTTPS) || (s.dest_port == PORT_HTTPS);
    end else if (udp && cfg_r.filter_mode == MODE_DNS) begin
      acc = (s.source_port == PORT_DNS) || (s.dest_port == PORT_DNS);
    end else if (tcp || udp) begin
      acc = ports_ok;
    end else begin
      acc = 1'b1;
    end
  end

  assign q_pop = q_rd.valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      accepted_r  <= acc;
      too_short_r <= shortf;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.accepted  = accepted_r;
  assign out_ch.too_short = too_short_r;

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("verdict popped but not presented");

  a_short_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !(acc && shortf))
    else $error("short frame judged as accepted");

endmodule

// ===== tb/phf_score_pkg.sv =====
// Verdict predictor and scoreboard for the packet header filter testbench.
package phf_score_pkg;
  import phf_pkg::*;

  typedef struct packed {
    logic accepted;
    logic too_short;
  } verdict_t;

  class verdict_board;
    localparam int WORD_BYTES = 4;

    cfg_t       cfg;
    logic [6:0]  offset;
    logic [15:0] kind;
    logic [7:0]  proto;
    logic [3:0]  hdr_words;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    verdict_t    verdicts_due[$];
    int          errors;
    int          checked;
    int          n_accepted;
    int          n_short;

    function new();
      cfg = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = '0;
      kind = '0;
      proto = '0;
      hdr_words = '0;
      src_addr = '0;
      dst_addr = '0;
      l4_src = '0;
      l4_dst = '0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function verdict_t judge_frame(int len, int port_pos);
      verdict_t v;
      logic     ports_ok;
      v = '0;
      ports_ok = (cfg.match_src_port == 0 || l4_src == cfg.match_src_port) &&
                 (cfg.match_dst_port == 0 || l4_dst == cfg.match_dst_port);
      if (len < LEN_ETH_MIN) begin
        v.too_short = 1'b1;
        return v;
      end
      if (cfg.filter_mode == MODE_ARP) begin
        v.accepted = (kind == ETH_KIND_ARP);
        return v;
      end
      if (kind != ETH_KIND_IPV4) return v;
      if (len < LEN_IPV4_MIN) begin
        v.too_short = 1'b1;
        return v;
      end
      if ((proto == PROTO_TCP || proto == PROTO_UDP) && len < port_pos + PORT_SPAN) begin
        v.too_short = 1'b1;
        return v;
      end
      if (cfg.match_protocol != 0 && proto != cfg.match_protocol) return v;
      if (cfg.src_addr_enable && src_addr != cfg.match_src_addr) return v;
      if (cfg.dst_addr_enable && dst_addr != cfg.match_dst_addr) return v;
      if (proto == PROTO_TCP) begin
        if (cfg.filter_mode == MODE_HTTP)
          v.accepted = (l4_src == PORT_HTTP || l4_dst == PORT_HTTP);
        else if (cfg.filter_mode == MODE_HTTPS)
          v.accepted = (l4_src == PORT_HTTPS || l4_dst == PORT_HTTPS);
        else
          v.accepted = ports_ok;
      end else if (proto == PROTO_UDP) begin
        if (cfg.filter_mode == MODE_DNS)
          v.accepted = (l4_src == PORT_DNS || l4_dst == PORT_DNS);
        else
          v.accepted = ports_ok;
      end else begin
        v.accepted = 1'b1;
      end
      return v;
    endfunction

    // One accepted byte beat; a verdict is due on the last byte.
    function void note_byte(logic [7:0] b, logic last);
      int o;
      int pp;
      o = offset;
      if (o < OFF_MAX && o == OFF_IP_START) hdr_words = b[3:0];
      pp = int'(OFF_IP_START) + WORD_BYTES * hdr_words;
      if (o < OFF_MAX) begin
        if (o == OFF_KIND_HI || o == OFF_KIND_LO) kind = {kind[7:0], b};
        if (o == OFF_PROTO) proto = b;
        if (o >= OFF_SRC_LO && o <= OFF_SRC_HI) src_addr = {src_addr[23:0], b};
        if (o >= OFF_DST_LO && o <= OFF_DST_HI) dst_addr = {dst_addr[23:0], b};
        if (o == pp || o == pp + 1) l4_src = {l4_src[7:0], b};
        if (o == pp + 2 || o == pp + 3) l4_dst = {l4_dst[7:0], b};
        offset = o + 1;
      end
      if (last) begin
        verdicts_due.push_back(judge_frame(o + 1, pp));
        clear_frame();
      end
    endfunction

    function void check_verdict(logic accepted, logic too_short);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict beat: accepted=%0b too_short=%0b", accepted, too_short);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (want.accepted) n_accepted++;
      if (want.too_short) n_short++;
      if (accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, accepted);
        errors++;
      end
      if (too_short !== want.too_short) begin
        $error("too_short: expected %0b, got %0b", want.too_short, too_short);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench of the packet header filter: frame stimulus and verdict checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phf_pkg::*;
  import phf_score_pkg::*;

  localparam int          IDLE_LIMIT    = 3000;
  localparam int          RANDOM_BEATS  = 250;
  localparam int          RANDOM_FRAMES = 8;
  localparam logic [2:0]  MODE_SPARE    = 3'd7;
  localparam logic [31:0] ADDR_A        = 32'hC0A8_0001;
  localparam logic [31:0] ADDR_B        = 32'h0A00_00FE;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_STINGY} ready_pat_t;

  typedef struct {
    logic [15:0] kind;
    logic [7:0]  proto;
    logic [3:0]  hw;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    int          len;
  } frame_spec_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [DATA_W-1:0] cfg_data;

  phf_in_if  in_ch();
  phf_out_if out_ch();

  packet_header_filter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  verdict_board board = new();

  int         burst_left  = 0;
  int         beats_sent  = 0;
  int         frames_sent = 0;
  int         settings    = 0;
  int         idle_cycles = 0;
  ready_pat_t ready_pat   = RDY_ALWAYS;
  int         pat_left    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stall pattern, re-drawn at random when its countdown runs out.
  always @(posedge clk) begin
    if (pat_left == 0) begin
      ready_pat <= ready_pat_t'($urandom_range(0, 3));
      pat_left  <= $urandom_range(16, 160);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (ready_pat)
      RDY_ALWAYS: out_ch.ready <= 1'b1;
      RDY_COIN:   out_ch.ready <= $urandom_range(0, 1);
      RDY_MOSTLY: out_ch.ready <= ($urandom_range(0, 7) != 0);
      default:    out_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_verdict(out_ch.accepted, out_ch.too_short);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no handshake for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.frame_end  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(b, last);
    beats_sent++;
    burst_left--;
  endtask

  task automatic send_frame(input frame_spec_t f);
    logic [7:0]  b;
    logic [31:0] ports;
    int          pp;
    pp = int'(OFF_IP_START) + 4 * f.hw;
    ports = {f.sp, f.dp};
    for (int i = 0; i < f.len; i++) begin
      b = $urandom;
      if (i == OFF_KIND_HI) b = f.kind[15:8];
      if (i == OFF_KIND_LO) b = f.kind[7:0];
      if (i == OFF_IP_START) b = {b[7:4], f.hw};
      if (i == OFF_PROTO) b = f.proto;
      if (i >= OFF_SRC_LO && i <= OFF_SRC_HI) b = f.sa[8 * (OFF_SRC_HI - i) +: 8];
      if (i >= OFF_DST_LO && i <= OFF_DST_HI) b = f.da[8 * (OFF_DST_HI - i) +: 8];
      if (i >= pp && i < pp + 4) b = ports[8 * (pp + 3 - i) +: 8];
      send_beat(b, i == f.len - 1);
    end
    frames_sent++;
  endtask

  // Sender holds off until every verdict is back and the pipeline is empty.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    reg_index_t  idx;
    logic [31:0] val;
    pause_until_drained();
    for (int i = 0; i < 8; i++) begin
      idx = reg_index_t'(i);
      case (idx)
        REG_FILTER_MODE:     val = c.filter_mode;
        REG_MATCH_PROTOCOL:  val = c.match_protocol;
        REG_MATCH_SRC_ADDR:  val = c.match_src_addr;
        REG_SRC_ADDR_ENABLE: val = c.src_addr_enable;
        REG_MATCH_DST_ADDR:  val = c.match_dst_addr;
        REG_DST_ADDR_ENABLE: val = c.dst_addr_enable;
        REG_MATCH_SRC_PORT:  val = c.match_src_port;
        default:             val = c.match_dst_port;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    board.cfg = c;
    settings++;
  endtask

  function automatic cfg_t make_cfg(logic [2:0] mode, logic [7:0] proto,
                                    logic [31:0] sa, logic sen, logic [31:0] da, logic den,
                                    logic [15:0] sp, logic [15:0] dp);
    cfg_t c;
    c.filter_mode     = mode;
    c.match_protocol  = proto;
    c.match_src_addr  = sa;
    c.src_addr_enable = sen;
    c.match_dst_addr  = da;
    c.dst_addr_enable = den;
    c.match_src_port  = sp;
    c.match_dst_port  = dp;
    return c;
  endfunction

  function automatic frame_spec_t spec(logic [15:0] kind, logic [7:0] proto, logic [3:0] hw,
                                       logic [31:0] sa, logic [31:0] da,
                                       logic [15:0] sp, logic [15:0] dp, int len);
    frame_spec_t f;
    f.kind = kind;
    f.proto = proto;
    f.hw = hw;
    f.sa = sa;
    f.da = da;
    f.sp = sp;
    f.dp = dp;
    f.len = len;
    return f;
  endfunction

  function automatic logic [15:0] pick_port(logic [15:0] wanted);
    case ($urandom_range(0, 6))
      0: return PORT_HTTP;
      1: return PORT_HTTPS;
      2: return PORT_DNS;
      3: return wanted;
      4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   r;
    c = '0;
    c.filter_mode = $urandom_range(0, 7);
    r = $urandom_range(0, 9);
    c.match_protocol = (r < 5) ? 8'd0 : (r < 7) ? PROTO_TCP : (r < 9) ? PROTO_UDP : 8'($urandom);
    c.match_src_addr  = $urandom;
    c.src_addr_enable = $urandom_range(0, 1);
    c.match_dst_addr  = $urandom;
    c.dst_addr_enable = $urandom_range(0, 1);
    c.match_src_port  = ($urandom_range(0, 9) < 6) ? 16'd0 : pick_port($urandom);
    c.match_dst_port  = ($urandom_range(0, 9) < 6) ? 16'd0 : pick_port($urandom);
    return c;
  endfunction

  // Mostly well-formed headers whose fields often hit the current filter settings.
  function automatic frame_spec_t rand_spec(cfg_t c);
    frame_spec_t f;
    int          r;
    int          needed;
    r = $urandom_range(0, 99);
    f.kind = (r < 70) ? ETH_KIND_IPV4 : (r < 85) ? ETH_KIND_ARP : 16'($urandom);
    r = $urandom_range(0, 99);
    f.proto = (r < 40) ? PROTO_TCP : (r < 75) ? PROTO_UDP : (r < 85) ? c.match_protocol
              : 8'($urandom);
    f.hw = ($urandom_range(0, 9) < 6) ? 4'd5 : 4'($urandom);
    f.sa = $urandom_range(0, 1) ? c.match_src_addr : $urandom;
    f.da = $urandom_range(0, 1) ? c.match_dst_addr : $urandom;
    f.sp = pick_port(c.match_src_port);
    f.dp = pick_port(c.match_dst_port);
    if (f.kind != ETH_KIND_IPV4 || c.filter_mode == MODE_ARP)
      needed = LEN_ETH_MIN;
    else if (f.proto == PROTO_TCP || f.proto == PROTO_UDP)
      needed = (18 + 4 * f.hw > LEN_IPV4_MIN) ? 18 + 4 * f.hw : LEN_IPV4_MIN;
    else
      needed = LEN_IPV4_MIN;
    r = $urandom_range(0, 99);
    if (r < 65)      f.len = needed + $urandom_range(0, 12);
    else if (r < 85) f.len = $urandom_range(1, needed);
    else if (r < 94) f.len = needed - 1;
    else             f.len = $urandom_range(120, 150);
    if (f.len < 1) f.len = 1;
    return f;
  endfunction

  task automatic run_directed();
    // reset settings: mode all, nothing required
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 80, 1234, 1));
    send_frame(spec(ETH_KIND_ARP, 0, 5, 0, 0, 0, 0, 13));
    send_frame(spec(ETH_KIND_ARP, 0, 5, 0, 0, 0, 0, 14));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 1, 2, 33));
    send_frame(spec(ETH_KIND_IPV4, 8'd1, 5, ADDR_A, ADDR_B, 1, 2, 34));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 1, 2, 37));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, '1, '0, 16'hFFFF, 16'h0000, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 15, '0, '1, 16'h0000, 16'hFFFF, 78));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 0, ADDR_A, ADDR_B, 16'h4500, 53, 34));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 80, 443, 130));
    send_frame(spec(16'h0000, 8'hFF, 4'hF, '1, '1, '1, '1, 20));

    write_config(make_cfg(MODE_ARP, 0, 0, 0, 0, 0, 0, 0));
    send_frame(spec(ETH_KIND_ARP, 0, 5, 0, 0, 0, 0, 14));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 80, 80, 20));
    send_frame(spec(ETH_KIND_ARP, 0, 5, 0, 0, 0, 0, 12));

    write_config(make_cfg(MODE_HTTP, PROTO_TCP, ADDR_A, 1, 0, 0, 0, 0));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 1000, 80, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 80, 7, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A + 1, ADDR_B, 80, 80, 38));

    write_config(make_cfg(MODE_HTTPS, 0, 0, 0, 0, 0, 0, 0));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 6, ADDR_A, ADDR_B, 5000, 443, 42));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 444, 80, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 5, ADDR_A, ADDR_B, 443, 9, 38));

    write_config(make_cfg(MODE_DNS, 0, 0, 0, ADDR_B, 1, 0, 0));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 5, ADDR_A, ADDR_B, 4000, 53, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 5, ADDR_A, ADDR_A, 53, 53, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 53, 1, 38));

    write_config(make_cfg(MODE_TCP, PROTO_UDP, 0, 0, 0, 0, 1234, 16'hFFFF));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 5, ADDR_A, ADDR_B, 1234, 16'hFFFF, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_UDP, 5, ADDR_A, ADDR_B, 1234, 16'hFFFE, 38));
    send_frame(spec(ETH_KIND_IPV4, PROTO_TCP, 5, ADDR_A, ADDR_B, 1234, 16'hFFFF, 38));

    write_config(make_cfg(MODE_UDP, 0, 0, 0, 0, 0, 0, 0));
    send_frame(spec(ETH_KIND_IPV4, 8'd1, 5, ADDR_A, ADDR_B, 0, 0, 34));
  endtask

  initial begin
    int   start_beats;
    int   start_frames;
    cfg_t c;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.frame_byte <= '0;
    in_ch.frame_end  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    start_beats  = beats_sent;
    start_frames = frames_sent;
    for (int p = 0; beats_sent - start_beats < RANDOM_BEATS ||
                    frames_sent - start_frames < RANDOM_FRAMES; p++) begin
      case (p)
        0: c = '0;
        1: c = make_cfg(MODE_UDP, 8'hFF, '1, 1, '1, 1, 16'hFFFF, 16'hFFFF);
        default: c = rand_cfg();
      endcase
      if (p == 2) c.filter_mode = MODE_SPARE;
      write_config(c);
      repeat ($urandom_range(2, 4)) begin
        send_frame(rand_spec(c));
        if ($urandom_range(0, 11) == 0) pause_until_drained();
      end
    end

    pause_until_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d frames (%0d byte beats) under %0d filter settings.",
             frames_sent, beats_sent, settings);
    $display("Verdicts checked: %0d (%0d accepted, %0d too short).",
             board.checked, board.n_accepted, board.n_short);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
